// ----- rtl/core/qvr_pkg.sv -----
`timescale 1ns / 1ps
package qvr_pkg;

  localparam int QUAT_WIDTH = 16;
  localparam int VEC_WIDTH  = 32;
  localparam int QFRAC      = QUAT_WIDTH - 2;

  // internal widths
  localparam int PROD_W = 2 * QUAT_WIDTH;        // quaternion part products
  localparam int NORM_W = 2 * QUAT_WIDTH + 1;    // squared norm, unsigned
  localparam int MAT_W  = 2 * QUAT_WIDTH + 2;    // scaled matrix entries
  localparam int MV_W   = MAT_W + VEC_WIDTH;     // entry times vector part
  localparam int SUM_W  = MV_W + 2;              // row sum
  localparam int NUM_W  = SUM_W + 1;             // 2*mag + n
  localparam int DEN_W  = NORM_W + 1;            // 2*n
  localparam int QUO_W  = VEC_WIDTH + 1;         // quotient bits, one per stage

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
  } in_word_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        saturated;
    logic                        zero_norm;
  } out_word_t;

endpackage

// ----- rtl/core/quaternion_vector_rotate_top.sv -----
`timescale 1ns / 1ps
// channel | signals                         | word
// --------+---------------------------------+------------------------------
// in      | in_valid, in_ready, in_data     | quaternion (Q1.14), vector (Q15.16)
// out     | out_valid, out_ready, out_data  | rotated vector, saturated, zero_norm
// cfg     | cfg_we, cfg_data                | unit_mode, written at once
//
// one word per cycle while the output is not stalled; 5 arithmetic stages,
// 33 restoring divider stages (one quotient bit per stage), one output register.
// rst is synchronous; it clears the valid bits and sets unit_mode to 1.
// the whole pipe advances when the output register is empty or being taken,
// so a stall freezes every stage and in_ready follows it.
module quaternion_vector_rotate_top import qvr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_data
);

  logic unit_mode;
  logic en;

  // stage 1: part products
  logic                     val1, gen1;
  logic signed [PROD_W-1:0] ww1, xx1, yy1, zz1, xy1, wz1, xz1, wy1, yz1, wx1;
  logic signed [VEC_WIDTH-1:0] v1 [0:2];

  // stage 2: norm and scaled matrix
  logic                       val2, gen2;
  logic        [NORM_W-1:0]   n2;
  logic signed [MAT_W-1:0]    m2 [0:8];
  logic signed [VEC_WIDTH-1:0] v2 [0:2];

  // stage 3: matrix times vector
  logic                    val3, gen3;
  logic [NORM_W-1:0]       n3;
  logic signed [MV_W-1:0]  p3 [0:8];

  // stage 4: row sums
  logic                    val4, gen4;
  logic [NORM_W-1:0]       n4;
  logic signed [SUM_W-1:0] s4 [0:2];

  // divider stages, index 0 is the load stage
  logic             dv_val  [0:QUO_W];
  logic             dv_gen  [0:QUO_W];
  logic             dv_zero [0:QUO_W];
  logic [DEN_W-1:0] dv_d    [0:QUO_W];
  logic             dv_neg  [0:QUO_W][0:2];
  logic [DEN_W-1:0] dv_r    [0:QUO_W][0:2];
  logic [QUO_W-1:0] dv_low  [0:QUO_W][0:2];
  logic [QUO_W-1:0] dv_q    [0:QUO_W][0:2];

  logic      ov;
  out_word_t od;

  assign en        = !ov || out_ready;
  assign in_ready  = en;
  assign out_valid = ov;
  assign out_data  = od;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode <= 1'b1;
    end else if (cfg_we) begin
      unit_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val1 <= 1'b0;
      val2 <= 1'b0;
      val3 <= 1'b0;
      val4 <= 1'b0;
    end else if (en) begin
      val1 <= in_valid;
      val2 <= val1;
      val3 <= val2;
      val4 <= val3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gen1 <= !unit_mode;
      ww1  <= PROD_W'(in_data.quat_w) * PROD_W'(in_data.quat_w);
      xx1  <= PROD_W'(in_data.quat_x) * PROD_W'(in_data.quat_x);
      yy1  <= PROD_W'(in_data.quat_y) * PROD_W'(in_data.quat_y);
      zz1  <= PROD_W'(in_data.quat_z) * PROD_W'(in_data.quat_z);
      xy1  <= PROD_W'(in_data.quat_x) * PROD_W'(in_data.quat_y);
      wz1  <= PROD_W'(in_data.quat_w) * PROD_W'(in_data.quat_z);
      xz1  <= PROD_W'(in_data.quat_x) * PROD_W'(in_data.quat_z);
      wy1  <= PROD_W'(in_data.quat_w) * PROD_W'(in_data.quat_y);
      yz1  <= PROD_W'(in_data.quat_y) * PROD_W'(in_data.quat_z);
      wx1  <= PROD_W'(in_data.quat_w) * PROD_W'(in_data.quat_x);
      v1[0] <= in_data.vec_x;
      v1[1] <= in_data.vec_y;
      v1[2] <= in_data.vec_z;

      gen2 <= gen1;
      n2   <= NORM_W'(ww1) + NORM_W'(xx1) + NORM_W'(yy1) + NORM_W'(zz1);
      m2[0] <= MAT_W'(ww1) + MAT_W'(xx1) - MAT_W'(yy1) - MAT_W'(zz1);
      m2[1] <= (MAT_W'(xy1) - MAT_W'(wz1)) <<< 1;
      m2[2] <= (MAT_W'(xz1) + MAT_W'(wy1)) <<< 1;
      m2[3] <= (MAT_W'(xy1) + MAT_W'(wz1)) <<< 1;
      m2[4] <= MAT_W'(ww1) - MAT_W'(xx1) + MAT_W'(yy1) - MAT_W'(zz1);
      m2[5] <= (MAT_W'(yz1) - MAT_W'(wx1)) <<< 1;
      m2[6] <= (MAT_W'(xz1) - MAT_W'(wy1)) <<< 1;
      m2[7] <= (MAT_W'(yz1) + MAT_W'(wx1)) <<< 1;
      m2[8] <= MAT_W'(ww1) - MAT_W'(xx1) - MAT_W'(yy1) + MAT_W'(zz1);
      v2   <= v1;

      gen3 <= gen2;
      n3   <= n2;
      for (int i = 0; i < 9; i++) begin
        p3[i] <= MV_W'(m2[i]) * MV_W'(v2[i % 3]);
      end

      gen4 <= gen3;
      n4   <= n3;
      for (int i = 0; i < 3; i++) begin
        s4[i] <= SUM_W'(p3[3*i]) + SUM_W'(p3[3*i+1]) + SUM_W'(p3[3*i+2]);
      end
    end
  end

  // load stage: magnitudes, unit-mode rounding, dividend and divisor
  logic             ld_neg [0:2];
  logic [DEN_W-1:0] ld_r   [0:2];
  logic [QUO_W-1:0] ld_low [0:2];
  logic [QUO_W-1:0] ld_q   [0:2];

  always_comb begin
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] rnd;
    logic [NUM_W-1:0] num;
    for (int i = 0; i < 3; i++) begin
      ld_neg[i] = s4[i][SUM_W-1];
      mag       = ld_neg[i] ? SUM_W'(-s4[i]) : SUM_W'(s4[i]);
      rnd       = (mag + (SUM_W'(1) << (2*QFRAC - 1))) >> (2*QFRAC);
      num       = {mag, 1'b0} + NUM_W'(n4);
      ld_r[i]   = num[QUO_W +: DEN_W];
      ld_low[i] = num[QUO_W-1:0];
      if (gen4) begin
        ld_q[i] = '0;
      end else if (rnd[SUM_W-1:QUO_W] != '0) begin
        ld_q[i] = '1;  // far beyond range, saturates anyway
      end else begin
        ld_q[i] = rnd[QUO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_val[0] <= 1'b0;
    end else if (en) begin
      dv_val[0] <= val4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_gen[0]  <= gen4;
      dv_zero[0] <= gen4 && (n4 == '0);
      dv_d[0]    <= {n4, 1'b0};
      dv_neg[0]  <= ld_neg;
      dv_r[0]    <= ld_r;
      dv_low[0]  <= ld_low;
      dv_q[0]    <= ld_q;
    end
  end

  // restoring divider, one quotient bit per stage; unit-mode words pass through
  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    logic [DEN_W:0] trial [0:2];
    logic           ge    [0:2];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {dv_r[k-1][i], dv_low[k-1][i][QUO_W-1]};
        ge[i]    = trial[i] >= {1'b0, dv_d[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_val[k] <= 1'b0;
      end else if (en) begin
        dv_val[k] <= dv_val[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_gen[k]  <= dv_gen[k-1];
        dv_zero[k] <= dv_zero[k-1];
        dv_d[k]    <= dv_d[k-1];
        dv_neg[k]  <= dv_neg[k-1];
        for (int i = 0; i < 3; i++) begin
          if (dv_gen[k-1]) begin
            dv_r[k][i]   <= ge[i] ? DEN_W'(trial[i] - {1'b0, dv_d[k-1]})
                                  : DEN_W'(trial[i]);
            dv_low[k][i] <= {dv_low[k-1][i][QUO_W-2:0], 1'b0};
            dv_q[k][i]   <= {dv_q[k-1][i][QUO_W-2:0], ge[i]};
          end else begin
            dv_r[k][i]   <= dv_r[k-1][i];
            dv_low[k][i] <= dv_low[k-1][i];
            dv_q[k][i]   <= dv_q[k-1][i];
          end
        end
      end
    end
  end

  // saturation and sign
  logic [VEC_WIDTH-1:0] fin_rot [0:2];
  logic                 fin_sat;

  always_comb begin
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mag;
    fin_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lim = (QUO_W'(1) << (VEC_WIDTH - 1)) - QUO_W'(!dv_neg[QUO_W][i]);
      if (dv_q[QUO_W][i] > lim) begin
        mag     = lim;
        fin_sat = 1'b1;
      end else begin
        mag = dv_q[QUO_W][i];
      end
      fin_rot[i] = dv_neg[QUO_W][i] ? VEC_WIDTH'(-mag) : VEC_WIDTH'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= dv_val[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_zero[QUO_W]) begin
        od.rot_x     <= '0;
        od.rot_y     <= '0;
        od.rot_z     <= '0;
        od.saturated <= 1'b0;
        od.zero_norm <= 1'b1;
      end else begin
        od.rot_x     <= fin_rot[0];
        od.rot_y     <= fin_rot[1];
        od.rot_z     <= fin_rot[2];
        od.saturated <= fin_sat;
        od.zero_norm <= 1'b0;
      end
    end
  end

  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_norm |-> out_data.rot_x == '0 &&
      out_data.rot_y == '0 && out_data.rot_z == '0 && !out_data.saturated)
    else $error("zero_norm word with nonzero payload");

  a_zero_general: assert property (@(posedge clk) disable iff (rst)
    dv_zero[QUO_W] |-> dv_gen[QUO_W])
    else $error("zero_norm raised in unit mode");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("word out right after reset");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import qvr_pkg::*;

  localparam int LATENCY = 39;
  localparam int N_RANDOM = 1000;

  typedef struct {
    in_word_t  word;
    logic      has_fixed;
    out_word_t fixed;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  logic      cfg_data;

  out_word_t rotations_due[$];
  logic      mode_unit;
  int        mismatches;
  bit        hold_off;

  quaternion_vector_rotate_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // round a signed row sum to the vector format and clip it
  function automatic logic signed [VEC_WIDTH-1:0] round_clip(
      input logic signed [127:0] s, input logic unit,
      input logic [127:0] nrm, inout logic sat);
    logic        neg;
    logic [127:0] mag;
    logic [127:0] lim;
    neg = s[127];
    mag = neg ? -s : s;
    if (unit) begin
      mag = (mag + (128'd1 << (2 * QFRAC - 1))) >> (2 * QFRAC);
    end else begin
      mag = ((mag << 1) + nrm) / (nrm << 1);
    end
    lim = (128'd1 << (VEC_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? -mag[VEC_WIDTH-1:0] : mag[VEC_WIDTH-1:0];
  endfunction

  function automatic out_word_t rotate_vector(input in_word_t d, input logic unit);
    logic signed [127:0] w, x, y, z, nrm, s;
    logic signed [127:0] m [3][3];
    logic signed [127:0] v [3];
    logic                sat;
    logic signed [VEC_WIDTH-1:0] r [3];
    out_word_t o;
    w = d.quat_w; x = d.quat_x; y = d.quat_y; z = d.quat_z;
    v[0] = d.vec_x; v[1] = d.vec_y; v[2] = d.vec_z;
    nrm = w*w + x*x + y*y + z*z;
    o = '0;
    if (!unit && nrm == 0) begin
      o.zero_norm = 1'b1;
      return o;
    end
    m[0][0] = w*w + x*x - y*y - z*z;
    m[1][1] = w*w - x*x + y*y - z*z;
    m[2][2] = w*w - x*x - y*y + z*z;
    m[0][1] = 2 * (x*y - w*z);
    m[1][0] = 2 * (x*y + w*z);
    m[0][2] = 2 * (x*z + w*y);
    m[2][0] = 2 * (x*z - w*y);
    m[1][2] = 2 * (y*z - w*x);
    m[2][1] = 2 * (y*z + w*x);
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
      r[i] = round_clip(s, unit, nrm, sat);
    end
    o.rot_x = r[0]; o.rot_y = r[1]; o.rot_z = r[2];
    o.saturated = sat;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) @(negedge clk);
  endtask

  // one word into the block, expectation queued at acceptance
  task automatic send_word(input in_word_t d, input logic has_fixed, input out_word_t fixed);
    int gap;
    gap = $urandom_range(0, 10) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      idle_cycles(gap);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rotations_due.push_back(has_fixed ? fixed : rotate_vector(d, mode_unit));
    @(negedge clk);
  endtask

  task automatic write_mode(input logic unit);
    in_valid <= 1'b0;
    while (rotations_due.size() != 0) @(negedge clk);
    idle_cycles(LATENCY + 2);
    cfg_we   <= 1'b1;
    cfg_data <= unit;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mode_unit  = unit;
  endtask

  function automatic in_word_t make_word(input int shape);
    in_word_t d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom};
    case (shape)
      0: begin
        // rotation-like quaternions with modest vectors
        d.quat_w = QUAT_WIDTH'($signed($urandom_range(0, 32767)) - 16384);
        d.quat_x = QUAT_WIDTH'($signed($urandom_range(0, 32767)) - 16384);
        d.quat_y = QUAT_WIDTH'($signed($urandom_range(0, 32767)) - 16384);
        d.quat_z = QUAT_WIDTH'($signed($urandom_range(0, 32767)) - 16384);
        d.vec_x  = $signed(d.vec_x) >>> $urandom_range(0, 16);
        d.vec_y  = $signed(d.vec_y) >>> $urandom_range(0, 16);
        d.vec_z  = $signed(d.vec_z) >>> $urandom_range(0, 16);
      end
      1: begin
        d.quat_w = $signed(d.quat_w) >>> $urandom_range(8, 15);
        d.quat_x = $signed(d.quat_x) >>> $urandom_range(8, 15);
        d.quat_y = $signed(d.quat_y) >>> $urandom_range(8, 15);
        d.quat_z = $signed(d.quat_z) >>> $urandom_range(8, 15);
      end
      2: begin
        d.quat_w = '0; d.quat_x = '0; d.quat_y = '0; d.quat_z = '0;
      end
      default: ;
    endcase
    return d;
  endfunction

  task automatic run_random(input int count);
    int shape;
    for (int i = 0; i < count; i++) begin
      shape = $urandom_range(0, 19);
      send_word(make_word(shape < 12 ? 0 : shape < 16 ? 1 : shape < 17 ? 2 : 3),
                1'b0, '0);
    end
  endtask

  // receiver; one long hold-off partway through
  initial begin
    int gap;
    out_word_t want;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        idle_cycles(300);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        out_ready <= 1'b0;
        idle_cycles(gap);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (rotations_due.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = rotations_due.pop_front();
        if (out_data.rot_x !== want.rot_x)
          report_mismatch("rot_x", out_data.rot_x, want.rot_x);
        if (out_data.rot_y !== want.rot_y)
          report_mismatch("rot_y", out_data.rot_y, want.rot_y);
        if (out_data.rot_z !== want.rot_z)
          report_mismatch("rot_z", out_data.rot_z, want.rot_z);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", out_data.saturated, want.saturated);
        if (out_data.zero_norm !== want.zero_norm)
          report_mismatch("zero_norm", out_data.zero_norm, want.zero_norm);
      end
      @(negedge clk);
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    localparam logic signed [QUAT_WIDTH-1:0] QONE = 1 << QFRAC;
    localparam logic signed [QUAT_WIDTH-1:0] QMIN = 1 << (QUAT_WIDTH - 1);
    localparam logic signed [QUAT_WIDTH-1:0] QMAX = QMIN - 1;
    localparam logic signed [VEC_WIDTH-1:0]  VMIN = 1 << (VEC_WIDTH - 1);
    localparam logic signed [VEC_WIDTH-1:0]  VMAX = VMIN - 1;
    rst = 1'b1; in_valid = 1'b0; in_data = '0; cfg_we = 1'b0; cfg_data = 1'b0;
    mismatches = 0; hold_off = 1'b0; mode_unit = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity and zero quaternion read off directly
    r.word = '{QONE, 0, 0, 0, 32'sd65536, -32'sd3, VMAX};
    r.has_fixed = 1'b1; r.fixed = '{32'sd65536, -32'sd3, VMAX, 1'b0, 1'b0};
    rows.push_back(r);
    r.word = '{0, 0, 0, 0, VMAX, VMIN, 32'sd77};
    r.fixed = '0; rows.push_back(r);
    r.has_fixed = 1'b0;
    r.word = '{0, QONE, 0, 0, 32'sd100, 32'sd200, 32'sd300}; rows.push_back(r);
    r.word = '{0, 0, QONE, 0, VMIN, VMAX, VMIN}; rows.push_back(r);
    r.word = '{0, 0, 0, QONE, VMAX, VMAX, VMAX}; rows.push_back(r);
    r.word = '{QMIN, QMIN, QMIN, QMIN, VMAX, VMIN, VMAX}; rows.push_back(r);
    r.word = '{QMAX, QMAX, QMAX, QMAX, VMIN, VMIN, VMIN}; rows.push_back(r);
    r.word = '{QMAX, QMIN, QMAX, QMIN, -32'sd1, 32'sd1, 32'sd0}; rows.push_back(r);
    r.word = '{11585, 11585, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536}; rows.push_back(r);
    r.word = '{1, 0, 0, 0, VMAX, 32'sd5, -32'sd5}; rows.push_back(r);
    r.word = '{-1, 1, -1, 1, VMIN, 32'sd1, VMAX}; rows.push_back(r);
    foreach (rows[i]) send_word(rows[i].word, rows[i].has_fixed, rows[i].fixed);

    write_mode(1'b0);
    r.word = '{0, 0, 0, 0, VMAX, VMIN, 32'sd9};
    r.has_fixed = 1'b1; r.fixed = '{0, 0, 0, 1'b0, 1'b1};
    send_word(r.word, 1'b1, r.fixed);
    foreach (rows[i]) send_word(rows[i].word, 1'b0, '0);

    run_random(N_RANDOM / 4);
    hold_off = 1'b1;
    run_random(N_RANDOM / 4);
    write_mode(1'b1);
    run_random(N_RANDOM / 4);
    write_mode(1'b0);
    run_random(N_RANDOM / 4);
    in_valid <= 1'b0;

    while (rotations_due.size() != 0) @(negedge clk);
    idle_cycles(LATENCY + 10);
    if (mismatches == 0 && rotations_due.size() == 0) begin
      $display("quaternion_vector_rotate_top test passed");
    end else begin
      $display("quaternion_vector_rotate_top test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("quaternion_vector_rotate_top test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/qvr_pkg.sv
rtl/core/quaternion_vector_rotate_top.sv
tb/testbench.sv
